// File: rtl/rrts_pkg.sv
// Shared constants and types for the round-robin task scheduler.
package rrts_pkg;

  // Task table size and the widths that follow from it.
  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Field widths of the request and response transactions.
  localparam int CMD_W     = 2;
  localparam int NOW_W     = 64;
  localparam int MS_W      = 32;
  localparam int ID_W      = 5;
  localparam int RUN_IDX_W = 4;
  localparam int RT_W      = 32;

  // Configuration port.
  localparam int RATE_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 1'd1;
  localparam logic [RATE_W-1:0]    RATE_RESET = 17'd1000;

  // Identifier handed out by the first create.
  localparam logic [ID_W-1:0] ID_FIRST_FREE = 5'd2;

  // Sleep conversion: milliseconds times rate, divided by one thousand.
  localparam int RATE_SCALE = 1000;
  localparam int PROD_W     = MS_W + RATE_W;
  localparam int DIG_W      = 4;
  localparam int DIV_STEPS  = (PROD_W + DIG_W - 1) / DIG_W;
  localparam int DIV_W      = DIV_STEPS * DIG_W;
  localparam int REM_W      = $clog2(RATE_SCALE);
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_SLEEP  = 2'd2,
    CMD_EXIT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_READY    = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_SLEEPING = 2'd2,
    ST_DEAD     = 2'd3
  } task_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FIN,
    S_DIV,
    S_RESULT
  } state_t;

endpackage

// File: rtl/rrts_req_if.sv
// Request channel: one command transaction per handshake.
interface rrts_req_if import rrts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [NOW_W-1:0] now_tick;
  logic [MS_W-1:0]  sleep_ms;

  modport source (output valid, cmd, now_tick, sleep_ms, input ready);
  modport sink   (input valid, cmd, now_tick, sleep_ms, output ready);
endinterface

// File: rtl/rrts_rsp_if.sv
// Response channel: one result transaction per command.
interface rrts_rsp_if import rrts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [ID_W-1:0]      new_task_id;
  logic                 switched;
  logic [RUN_IDX_W-1:0] running_index;
  logic [RT_W-1:0]      prev_run_ticks;

  modport source (output valid, status, new_task_id, switched, running_index,
                  prev_run_ticks, input ready);
  modport sink   (input valid, status, new_task_id, switched, running_index,
                  prev_run_ticks, output ready);
endinterface

// File: rtl/rrts_div.sv
// Divide-by-one-thousand unit, four quotient bits per cycle.
module rrts_div import rrts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  localparam logic [REM_W:0]  SCALE     = (REM_W + 1)'(RATE_SCALE);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  work;
  logic [REM_W-1:0]  rem;
  logic [DIV_W-1:0]  work_next;
  logic [REM_W-1:0]  rem_next;

  // One radix-16 digit: four restoring compare-and-subtract steps.
  always_comb begin
    logic [REM_W:0]   trial;
    logic [DIG_W-1:0] digit;
    rem_next = rem;
    digit    = '0;
    trial    = '0;
    for (int b = 0; b < DIG_W; b++) begin
      trial = {rem_next, work[DIV_W-1-b]};
      if (trial >= SCALE) begin
        rem_next          = REM_W'(trial - SCALE);
        digit[DIG_W-1-b]  = 1'b1;
      end else begin
        rem_next = trial[REM_W-1:0];
      end
    end
    work_next = {work[DIV_W-DIG_W-1:0], digit};
  end

  // Control: busy while digits remain, done pulses once the quotient is complete.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= DIV_W'(dividend);
      rem  <= '0;
      step <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
      step <= step + STEP_W'(1);
    end
  end

  assign quotient = work[PROD_W-1:0];

endmodule

// File: rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler with sleep timers.
//
// Commands arrive on the req channel (valid/ready); each one produces exactly
// one transaction on the rsp channel. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_wdata): index 0 is the scheduler enable, index 1 the tick rate in
// hertz; the user must write it only while no command is in work (unchecked).
//
// One command is in work at a time; req.ready is high while the block is idle.
// Create and exit go from decode straight to the result state. Sleep waits in
// the divide-by-1000 unit, which retires four quotient bits per cycle. A
// scheduling tick passes through a table scan and a final state before the
// result: the wake-up and round-robin pick walk the task table one entry per
// cycle through the wake-time memory read port. A disabled tick or a tick
// with one task skips the scan and goes straight to the result state.
//
// The response sits in an output register. A new command is accepted while
// that response is still waiting; its own response waits until the receiver
// takes the old one. Synchronous reset restores the idle task as the only,
// running, task and needs no clearing pass.
module round_robin_task_scheduler import rrts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rrts_req_if.sink              req,
  rrts_rsp_if.source            rsp
);

  state_t state, state_next;

  // Configuration registers.
  logic              sched_en;
  logic [RATE_W-1:0] tick_rate;

  // Task table: status in flops, run ticks and wake times in memories.
  task_state_t      task_status [MAX_TASKS];
  logic [MAX_TASKS-1:0] rt_vld;
  logic [RT_W-1:0]  rt_mem   [MAX_TASKS];
  logic [NOW_W-1:0] wake_mem [MAX_TASKS];

  logic [CNT_W-1:0] tasks_in_use;
  logic [IDX_W-1:0] cur;
  logic [ID_W-1:0]  next_ident;

  // Captured command.
  cmd_t             cmd_q;
  logic [NOW_W-1:0] now_q;
  logic [MS_W-1:0]  ms_q;

  // Memory read data.
  logic [RT_W-1:0]  rt_rd;
  logic             rt_rd_vld;
  logic [NOW_W-1:0] wake_rd;

  // Table scan.
  logic [IDX_W-1:0] scan_idx;
  logic [CNT_W-1:0] scan_cnt;
  logic             cmp_vld;
  logic             cmp_last;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] pick;

  // Result being built and the output register.
  logic                 res_status;
  logic [ID_W-1:0]      res_newid;
  logic                 res_sw;
  logic [RT_W-1:0]      res_prev;
  logic                 rsp_valid;
  logic                 rsp_status;
  logic [ID_W-1:0]      rsp_newid;
  logic                 rsp_sw;
  logic [RUN_IDX_W-1:0] rsp_run_idx;
  logic [RT_W-1:0]      rsp_prev;

  // Control and write ports.
  logic              req_fire;
  logic              tick_active;
  logic              table_full;
  logic [IDX_W-1:0]  new_slot;
  logic [RT_W-1:0]   cur_rt;
  logic              rt_we;
  logic              issue;
  logic              rsp_load;
  task_state_t       cmp_st;
  logic              wake_hit;
  logic              eff_ready;
  logic              do_switch;
  logic              st_we;
  logic [IDX_W-1:0]  st_wa;
  task_state_t       st_wd;
  logic              wk_we;
  logic [IDX_W-1:0]  wk_wa;
  logic [NOW_W-1:0]  wk_wd;
  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] div_quot;
  logic [PROD_W-1:0] product;
  logic [NOW_W-1:0]  deadline;

  // Next table index in round-robin order among the tasks in use.
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] count);
    return (CNT_W'(idx) + CNT_W'(1) == count) ? '0 : idx + IDX_W'(1);
  endfunction

  assign req.ready   = (state == S_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign tick_active = sched_en && (tasks_in_use > CNT_W'(1));
  assign table_full  = (tasks_in_use >= CNT_W'(MAX_TASKS));
  assign new_slot    = tasks_in_use[IDX_W-1:0];
  assign cur_rt      = rt_rd_vld ? rt_rd : '0;
  assign rt_we       = (state == S_DECODE) && (cmd_q == CMD_TICK) && tick_active;
  assign issue       = (state == S_SCAN) && (scan_cnt != tasks_in_use);
  assign rsp_load    = (state == S_RESULT) && (!rsp_valid || rsp.ready);
  assign cmp_st      = task_status[cmp_idx];
  assign wake_hit    = (cmp_st == ST_SLEEPING) && (now_q >= wake_rd);
  assign eff_ready   = (cmp_st == ST_READY) || wake_hit;
  assign do_switch   = found && (pick != cur);
  assign product     = PROD_W'(ms_q) * PROD_W'(tick_rate);
  assign deadline    = now_q + NOW_W'(div_quot) + NOW_W'(1);

  // Sleep deadline divider.
  rrts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_fire) state_next = S_DECODE;
      S_DECODE: begin
        unique case (cmd_q)
          CMD_TICK:   state_next = tick_active ? S_SCAN : S_RESULT;
          CMD_SLEEP:  state_next = S_DIV;
          CMD_CREATE: state_next = S_RESULT;
          CMD_EXIT:   state_next = S_RESULT;
        endcase
      end
      S_SCAN:   if (cmp_vld && cmp_last) state_next = S_FIN;
      S_FIN:    state_next = S_RESULT;
      S_DIV:    if (div_done) state_next = S_RESULT;
      S_RESULT: if (rsp_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Write ports of the status table and the wake-time memory, and the divider start.
  always_comb begin
    st_we     = 1'b0;
    st_wa     = cur;
    st_wd     = ST_READY;
    wk_we     = 1'b0;
    wk_wa     = cur;
    wk_wd     = '0;
    div_start = 1'b0;
    unique case (state)
      S_DECODE: begin
        unique case (cmd_q)
          CMD_CREATE: begin
            if (!table_full) begin
              st_we = 1'b1;
              st_wa = new_slot;
              st_wd = ST_READY;
              wk_we = 1'b1;
              wk_wa = new_slot;
              wk_wd = '0;
            end
          end
          CMD_EXIT: begin
            st_we = 1'b1;
            st_wd = ST_DEAD;
          end
          CMD_SLEEP: div_start = 1'b1;
          CMD_TICK:  div_start = 1'b0;
        endcase
      end
      S_SCAN: begin
        // Wake an expired sleeper; on the final visit, demote the running task
        // if another one was picked.
        if (cmp_vld) begin
          if (wake_hit) begin
            st_we = 1'b1;
            st_wa = cmp_idx;
            st_wd = ST_READY;
          end else if (cmp_last && found && cmp_st == ST_RUNNING) begin
            st_we = 1'b1;
            st_wa = cmp_idx;
            st_wd = ST_READY;
          end
        end
      end
      S_FIN: begin
        if (do_switch) begin
          st_we = 1'b1;
          st_wa = pick;
          st_wd = ST_RUNNING;
        end
      end
      S_DIV: begin
        if (div_done) begin
          st_we = 1'b1;
          st_wd = ST_SLEEPING;
          wk_we = 1'b1;
          wk_wd = deadline;
        end
      end
      default: st_we = 1'b0;
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sched_en     <= 1'b0;
      tick_rate    <= RATE_RESET;
      tasks_in_use <= CNT_W'(1);
      cur          <= '0;
      next_ident   <= ID_FIRST_FREE;
      rt_vld       <= '0;
      rsp_valid    <= 1'b0;
      cmp_vld      <= 1'b0;
      found        <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        task_status[i] <= (i == 0) ? ST_RUNNING : ST_READY;
      end
    end else begin
      state   <= state_next;
      cmp_vld <= issue;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE: sched_en  <= cfg_wdata[0];
          CFG_RATE:   tick_rate <= cfg_wdata[RATE_W-1:0];
        endcase
      end

      if (st_we) task_status[st_wa] <= st_wd;

      if (state == S_DECODE) begin
        found <= 1'b0;
        if (cmd_q == CMD_CREATE && !table_full) begin
          tasks_in_use     <= tasks_in_use + CNT_W'(1);
          next_ident       <= next_ident + ID_W'(1);
          rt_vld[new_slot] <= 1'b0;
        end
      end
      if (rt_we) rt_vld[cur] <= 1'b1;

      if (state == S_SCAN && cmp_vld && eff_ready && !found) found <= 1'b1;
      if (state == S_FIN && do_switch) cur <= pick;

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q      <= cmd_t'(req.cmd);
      now_q      <= req.now_tick;
      ms_q       <= req.sleep_ms;
      res_status <= 1'b0;
      res_newid  <= '0;
      res_sw     <= 1'b0;
      rt_rd_vld  <= rt_vld[cur];
    end

    if (state == S_DECODE) begin
      res_prev <= rt_we ? cur_rt + RT_W'(1) : cur_rt;
      scan_idx <= wrap_inc(cur, tasks_in_use);
      scan_cnt <= '0;
      if (cmd_q == CMD_CREATE) begin
        if (table_full) begin
          res_status <= 1'b1;
        end else begin
          res_newid <= next_ident;
        end
      end
    end

    if (issue) begin
      scan_idx <= wrap_inc(scan_idx, tasks_in_use);
      scan_cnt <= scan_cnt + CNT_W'(1);
      cmp_idx  <= scan_idx;
      cmp_last <= (scan_cnt == tasks_in_use - CNT_W'(1));
    end

    if (state == S_SCAN && cmp_vld && eff_ready && !found) pick <= cmp_idx;
    if (state == S_FIN && do_switch) res_sw <= 1'b1;

    if (rsp_load) begin
      rsp_status  <= res_status;
      rsp_newid   <= res_newid;
      rsp_sw      <= res_sw;
      rsp_run_idx <= RUN_IDX_W'(cur);
      rsp_prev    <= res_prev;
    end
  end

  // Run-tick memory: read of the current entry at acceptance, increment on a tick_active tick.
  always_ff @(posedge clk) begin
    if (req_fire) rt_rd <= rt_mem[cur];
    if (rt_we) rt_mem[cur] <= cur_rt + RT_W'(1);
  end

  // Wake-time memory: one scan read a cycle, one write port.
  always_ff @(posedge clk) begin
    if (issue) wake_rd <= wake_mem[scan_idx];
    if (wk_we) wake_mem[wk_wa] <= wk_wd;
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.new_task_id    = rsp_newid;
  assign rsp.switched       = rsp_sw;
  assign rsp.running_index  = rsp_run_idx;
  assign rsp.prev_run_ticks = rsp_prev;

endmodule

// File: rtl/rrts_checker.sv
// Port-level checks for the round-robin task scheduler, bound to the top level.
module rrts_checker import rrts_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic                 rsp_status,
  input logic [ID_W-1:0]      rsp_new_task_id,
  input logic                 rsp_switched,
  input logic [RUN_IDX_W-1:0] rsp_running_index,
  input logic [RT_W-1:0]      rsp_prev_run_ticks
);

  // A stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_new_task_id) && $stable(rsp_switched) &&
      $stable(rsp_running_index) && $stable(rsp_prev_run_ticks))
    else $error("response changed while stalled");

  // A full-table answer carries no identifier and no task switch.
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_new_task_id == '0 && !rsp_switched)
    else $error("full-table response carries extra fields");

  // A switch comes only from a tick, which never creates a task.
  a_switch_only_tick: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_switched |-> !rsp_status && rsp_new_task_id == '0)
    else $error("switch reported together with a create result");

  // One command at a time: acceptance closes the request side.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second command accepted while one is in work");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_new_task_id    (rsp.new_task_id),
  .rsp_switched       (rsp.switched),
  .rsp_running_index  (rsp.running_index),
  .rsp_prev_run_ticks (rsp.prev_run_ticks)
);

// File: tb/testbench.sv
// Self-checking testbench for the round-robin task scheduler with sleep timers.
module testbench;
  import rrts_pkg::*;

  localparam int          SETTLE_CYCLES = 30;
  localparam int          STALL_LIMIT   = 4000;
  localparam logic [63:0] MS_PER_SEC    = 64'd1000;

  // One command as it travels on the request channel.
  typedef struct packed {
    cmd_t             cmd;
    logic [NOW_W-1:0] now_tick;
    logic [MS_W-1:0]  sleep_ms;
  } sched_cmd_t;

  // One response as the scheduler should return it.
  typedef struct packed {
    logic                 status;
    logic [ID_W-1:0]      new_task_id;
    logic                 switched;
    logic [RUN_IDX_W-1:0] running_index;
    logic [RT_W-1:0]      prev_run_ticks;
  } sched_rsp_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rrts_req_if cmd_ch ();
  rrts_rsp_if result_ch ();

  round_robin_task_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (cmd_ch),
    .rsp       (result_ch)
  );

  // Shadow copy of the task table and the configuration.
  task_state_t        task_state [MAX_TASKS];
  logic [NOW_W-1:0]   task_wake  [MAX_TASKS];
  logic [RT_W-1:0]    task_runs  [MAX_TASKS];
  int                 live_tasks;
  int                 running_slot;
  logic [ID_W-1:0]    next_id;
  logic               sched_on;
  logic [RATE_W-1:0]  tick_rate;

  sched_cmd_t pending_cmds [$];
  sched_rsp_t due_responses [$];
  sched_cmd_t on_bus;
  int         cmds_queued;
  int         cmds_taken;
  int         mismatch_count;
  int         gap_left;
  int         stall_left;
  int         hold_left;
  int         hold_request;
  int         idle_cycles;
  bit         jitter_on;
  logic [NOW_W-1:0] wall_ticks;

  // Clock with a period of two time units.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Gap length between transactions: none without jitter, else mostly none, some short, a few long.
  function automatic int draw_gap();
    int roll;
    if (!jitter_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Puts the shadow table and configuration in their post-reset state.
  function automatic void clear_tasks();
    for (int i = 0; i < MAX_TASKS; i++) begin
      task_state[i] = ST_READY;
      task_wake[i]  = '0;
      task_runs[i]  = '0;
    end
    task_state[0] = ST_RUNNING;
    live_tasks    = 1;
    running_slot  = 0;
    next_id       = ID_FIRST_FREE;
    sched_on      = 1'b0;
    tick_rate     = RATE_RESET;
  endfunction

  // Applies one command to the shadow table and returns the response it owes.
  function automatic sched_rsp_t schedule_step(sched_cmd_t c);
    sched_rsp_t       r;
    int               prev;
    int               pick;
    int               slot;
    logic [NOW_W-1:0] delay;
    r    = '0;
    prev = running_slot;
    case (c.cmd)
      CMD_TICK: begin
        if (sched_on && live_tasks > 1) begin
          task_runs[prev] = task_runs[prev] + RT_W'(1);
          // Wake every sleeper whose deadline has been reached.
          for (int i = 0; i < live_tasks; i++) begin
            if (task_state[i] == ST_SLEEPING && c.now_tick >= task_wake[i])
              task_state[i] = ST_READY;
          end
          // Round-robin search for the next ready task after the current one.
          pick = prev;
          for (int k = 1; k <= live_tasks; k++) begin
            slot = (prev + k) % live_tasks;
            if (pick == prev && task_state[slot] == ST_READY) pick = slot;
          end
          if (pick != prev) begin
            if (task_state[prev] == ST_RUNNING) task_state[prev] = ST_READY;
            task_state[pick] = ST_RUNNING;
            running_slot     = pick;
            r.switched       = 1'b1;
          end
        end
      end
      CMD_CREATE: begin
        if (live_tasks >= MAX_TASKS) begin
          r.status = 1'b1;
        end else begin
          task_state[live_tasks] = ST_READY;
          task_wake[live_tasks]  = '0;
          task_runs[live_tasks]  = '0;
          r.new_task_id          = next_id;
          next_id                = next_id + ID_W'(1);
          live_tasks++;
        end
      end
      CMD_SLEEP: begin
        delay           = (64'(c.sleep_ms) * 64'(tick_rate)) / MS_PER_SEC;
        task_wake[prev] = c.now_tick + delay + 64'd1;
        task_state[prev] = ST_SLEEPING;
      end
      default: begin
        task_state[prev] = ST_DEAD;
      end
    endcase
    r.running_index  = RUN_IDX_W'(running_slot);
    r.prev_run_ticks = task_runs[prev];
    return r;
  endfunction

  // Counts a wrong field and reports the first few.
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Driver: presents queued commands and predicts each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        due_responses.push_back(schedule_step(on_bus));
        cmds_taken++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          on_bus = pending_cmds.pop_front();
          cmd_ch.valid    <= 1'b1;
          cmd_ch.cmd      <= on_bus.cmd;
          cmd_ch.now_tick <= on_bus.now_tick;
          cmd_ch.sleep_ms <= on_bus.sleep_ms;
          gap_left = draw_gap();
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver flow control, including the long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      stall_left = draw_gap();
    end
  end

  // Monitor: compares every response transaction with the oldest prediction.
  always @(posedge clk) begin
    sched_rsp_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (due_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("response arrived with none outstanding");
      end else begin
        want = due_responses.pop_front();
        check_field("status", 64'(want.status), 64'(result_ch.status));
        check_field("new_task_id", 64'(want.new_task_id), 64'(result_ch.new_task_id));
        check_field("switched", 64'(want.switched), 64'(result_ch.switched));
        check_field("running_index", 64'(want.running_index),
                    64'(result_ch.running_index));
        check_field("prev_run_ticks", 64'(want.prev_run_ticks),
                    64'(result_ch.prev_run_ticks));
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send(input cmd_t c, input logic [NOW_W-1:0] now, input logic [MS_W-1:0] ms);
    sched_cmd_t item;
    item.cmd      = c;
    item.now_tick = now;
    item.sleep_ms = ms;
    pending_cmds.push_back(item);
    cmds_queued++;
  endtask

  // Waits until every command is taken and answered, then lets the block settle.
  task automatic drain();
    while (cmds_taken != cmds_queued || due_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the scheduler is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ENABLE) sched_on = data[0];
    else tick_rate = data[RATE_W-1:0];
  endtask

  // Random phase: mostly ticks on an advancing clock with short sleeps, some
  // creates, a bounded number of exits, and a little noise.
  task automatic run_phase(input logic en, input logic [RATE_W-1:0] rate, input int count,
                           input int exits, input bit jitter, input int hold);
    int              roll;
    int              span;
    logic [MS_W-1:0] ms;
    write_reg(CFG_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_RATE, rate);
    jitter_on  = jitter;
    wall_ticks = {$urandom, $urandom};
    span       = (rate == '0) ? 1000 : 8000 / int'(rate) + 1;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 52) begin
        send(CMD_TICK, wall_ticks, $urandom);
        wall_ticks = wall_ticks + 64'($urandom_range(0, 3));
      end else if (roll < 64) begin
        send(CMD_CREATE, {$urandom, $urandom}, $urandom);
      end else if (roll < 88) begin
        ms = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, span);
        send(CMD_SLEEP, wall_ticks, ms);
      end else if (roll < 93 && exits > 0) begin
        send(CMD_EXIT, {$urandom, $urandom}, $urandom);
        exits--;
      end else if (roll < 97) begin
        send(CMD_TICK, {$urandom, $urandom}, $urandom);
      end else begin
        send(CMD_SLEEP, {$urandom, $urandom}, $urandom);
      end
    end
    hold_request = hold;
    drain();
  endtask

  // Stimulus sequence.
  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_ENABLE;
    cfg_wdata        = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.cmd       = CMD_TICK;
    cmd_ch.now_tick  = '0;
    cmd_ch.sleep_ms  = '0;
    result_ch.ready  = 1'b0;
    cmds_queued      = 0;
    cmds_taken       = 0;
    mismatch_count   = 0;
    hold_request     = 0;
    idle_cycles      = 0;
    jitter_on        = 1'b1;
    wall_ticks       = '0;
    clear_tasks();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Scheduler still disabled: ticks do nothing, the idle task may sleep.
    send(CMD_TICK, '0, '0);
    send(CMD_TICK, '1, '1);
    send(CMD_SLEEP, '0, '0);
    drain();

    // Enabled with a single task, then a small table walked by hand.
    write_reg(CFG_ENABLE, CFG_DATA_W'(1));
    write_reg(CFG_RATE, RATE_RESET);
    send(CMD_TICK, 64'd5, '0);
    send(CMD_CREATE, '0, '0);
    send(CMD_TICK, 64'd0, '0);
    send(CMD_TICK, 64'd1, '0);
    send(CMD_CREATE, '0, '0);
    send(CMD_CREATE, '0, '0);
    send(CMD_EXIT, '0, '0);
    send(CMD_TICK, 64'd2, '0);
    send(CMD_SLEEP, '1, '1);
    send(CMD_TICK, 64'd5, '0);
    send(CMD_EXIT, '0, '0);
    send(CMD_TICK, 64'd6, '0);
    send(CMD_SLEEP, 64'd10, 32'd5);
    send(CMD_TICK, 64'd11, '0);
    send(CMD_TICK, '1, '0);
    drain();

    // Rate extremes on the sleep conversion.
    write_reg(CFG_RATE, '0);
    send(CMD_SLEEP, 64'd100, '1);
    send(CMD_TICK, 64'd100, '0);
    drain();
    write_reg(CFG_RATE, CFG_DATA_W'(100000));
    send(CMD_SLEEP, '0, '1);
    send(CMD_TICK, 64'd1, '0);
    drain();
    write_reg(CFG_RATE, CFG_DATA_W'(1));
    send(CMD_SLEEP, '0, 32'd999);
    send(CMD_TICK, 64'd1, '0);
    drain();

    // Random phases; the first one also holds the receiver off for a long stretch.
    run_phase(1'b1, RATE_RESET, 300, 2, 1'b1, 400);
    run_phase(1'b1, RATE_W'(1), 200, 2, 1'b0, 0);
    run_phase(1'b0, RATE_W'(100000), 100, 2, 1'b1, 0);
    run_phase(1'b1, RATE_W'(100000), 250, 2, 1'b1, 0);
    run_phase(1'b1, RATE_W'($urandom_range(1, 100000)), 250, 2, 1'b1, 0);
    // Last phase lets exits take every task down.
    run_phase(1'b1, RATE_W'($urandom_range(1, 100000)), 60, 40, 1'b1, 0);

    if (mismatch_count == 0 && due_responses.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
